// ===== design/smr_pkg.sv =====
// smr_pkg: shared types, constants and helpers for the seir metapopulation rhs block
// depends on nothing; used by every module of the block
package smr_pkg;

    localparam int VAL_W         = 48;
    localparam int FLOW_W        = 32;
    localparam int CFG_W         = 20;
    localparam int IDX_W         = 3;
    localparam int OPW           = 64;
    localparam int PROD_W        = 61;
    localparam int SUM_W         = 56;
    localparam int OUT_W         = 48;
    localparam int TMP_N         = 17;
    localparam int STEP_W        = 5;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [PROD_W-1:0] PROD_CAP = {1'b1, {(PROD_W-1){1'b0}}};

    // register indexes of the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_BETA  = 3'd0,
        REG_MU    = 3'd1,
        REG_ALPHA = 3'd2,
        REG_INV_Z = 3'd3,
        REG_INV_D = 3'd4,
        REG_THETA = 3'd5
    } reg_idx_t;

    typedef enum logic {
        MODE_REGION   = 1'b0,
        MODE_NEIGHBOR = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_FRAC = 2'd1,
        SH_WORD = 2'd2
    } shift_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        AR_IDLE,
        AR_MUL,
        AR_NORM,
        AR_DIV,
        AR_CAP
    } ar_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_WAIT,
        BK_FINISH,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        logic              mode;
        logic [VAL_W-1:0]  susceptible;
        logic [VAL_W-1:0]  exposed;
        logic [VAL_W-1:0]  documented;
        logic [VAL_W-1:0]  undocumented;
        logic [VAL_W-1:0]  population;
        logic [VAL_W-1:0]  ext_commuters;
        logic [FLOW_W-1:0] flow_in;
        logic [FLOW_W-1:0] flow_out;
        logic              last_of_region;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] rate_susceptible;
        logic signed [OUT_W-1:0] rate_exposed;
        logic signed [OUT_W-1:0] rate_documented;
        logic signed [OUT_W-1:0] rate_undocumented;
        logic signed [OUT_W-1:0] rate_population;
        logic                    divide_fault;
    } out_word_t;

    // classified word handed from front to back
    typedef struct packed {
        in_word_t          item;
        logic [VAL_W-1:0]  exch_base;
        logic [VAL_W:0]    inf_sum;
        logic [FLOW_W-1:0] flow_mag;
        logic              flow_neg;
    } cmd_t;

    typedef struct packed {
        logic [19:0] beta;
        logic [16:0] mu;
        logic [16:0] alpha;
        logic [16:0] inv_z;
        logic [16:0] inv_d;
        logic [19:0] theta;
    } cfg_t;

    typedef struct packed {
        logic           start;
        op_t            op;
        shift_t         sh;
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
    } arith_req_t;

    typedef struct packed {
        logic              done;
        logic              zero_div;
        logic [PROD_W-1:0] result;
    } arith_rsp_t;

    function automatic logic signed [63:0] to_s64(input logic [PROD_W-1:0] x);
        return $signed({{(64-PROD_W){1'b0}}, x});
    endfunction

    // clamp to a signed range of the given width
    function automatic logic signed [63:0] sat_bits(input logic signed [63:0] v,
                                                     input int unsigned bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

endpackage

// ===== design/smr_front.sv =====
// smr_front: takes input words, classifies them and queues them for the back end
// depends on smr_pkg
module smr_front
    import smr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_word_t item,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_take
);

    cmd_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;
    cmd_t       cls;

    // classification: exchange divisor, infection sum, net flow
    always_comb
    begin
        cls.item = item;
        if (item.population > item.documented)
        begin
            cls.exch_base = item.population - item.documented;
        end
        else
        begin
            cls.exch_base = '0;
        end
        cls.inf_sum = {1'b0, item.documented} + {1'b0, item.ext_commuters};
        if (item.flow_in >= item.flow_out)
        begin
            cls.flow_mag = item.flow_in - item.flow_out;
            cls.flow_neg = 1'b0;
        end
        else
        begin
            cls.flow_mag = item.flow_out - item.flow_in;
            cls.flow_neg = 1'b1;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // queue pointers
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== design/smr_arith.sv =====
// smr_arith: shared multi-cycle multiplier (32x32 partial products) and reciprocal divider
// depends on smr_pkg
module smr_arith
    import smr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    localparam int NW = FRAC_BITS + 33;
    localparam int CW = $clog2(NW + 1);

    ar_state_t         state_reg, state_next;
    logic [OPW-1:0]    a_reg, a_next;
    logic [OPW-1:0]    b_reg, b_next;
    shift_t            sh_reg, sh_next;
    logic [127:0]      acc_reg, acc_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [VAL_W-1:0]  rem_reg, rem_next;
    logic [NW-1:0]     quo_reg, quo_next;
    logic [PROD_W-1:0] res_reg, res_next;
    logic              done_reg, done_next;
    logic              zero_reg, zero_next;

    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] shifted;
    logic [VAL_W:0] trial;
    logic [63:0]  quo_ext;

    // partial product of the current halves
    always_comb
    begin
        a_half = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        b_half = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        pp     = 64'(a_half) * 64'(b_half);
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'b0, pp};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
    end

    // normalizing shift of the full product
    always_comb
    begin
        case (sh_reg)
            SH_FRAC: shifted = acc_reg >> FRAC_BITS;
            SH_WORD: shifted = acc_reg >> 32;
            default: shifted = acc_reg;
        endcase
    end

    // one quotient bit a cycle; the dividend is a single one bit at the top
    assign trial   = {rem_reg, (cnt_reg == CW'(0))};
    assign quo_ext = 64'(quo_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AR_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == OP_MUL)
                    begin
                        state_next = AR_MUL;
                    end
                    else if (req.b[VAL_W-1:0] != '0)
                    begin
                        state_next = AR_DIV;
                    end
                end
            end
            AR_MUL:
            begin
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = AR_NORM;
                end
            end
            AR_NORM: state_next = AR_IDLE;
            AR_DIV:
            begin
                if (cnt_reg == CW'(NW - 1))
                begin
                    state_next = AR_CAP;
                end
            end
            AR_CAP:  state_next = AR_IDLE;
            default: state_next = AR_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        unique case (state_reg)
            AR_IDLE:
            begin
                if (req.start)
                begin
                    a_next    = req.a;
                    b_next    = req.b;
                    sh_next   = req.sh;
                    acc_next  = '0;
                    cnt_next  = '0;
                    rem_next  = '0;
                    quo_next  = '0;
                    zero_next = 1'b0;
                    if (req.op == OP_DIV && req.b[VAL_W-1:0] == '0)
                    begin
                        res_next  = '0;
                        zero_next = 1'b1;
                        done_next = 1'b1;
                    end
                end
            end
            AR_MUL:
            begin
                acc_next = acc_reg + pp_sh;
                cnt_next = cnt_reg + CW'(1);
            end
            AR_NORM:
            begin
                if ((|shifted[127:PROD_W]) || (shifted[PROD_W-1] && (|shifted[PROD_W-2:0])))
                begin
                    res_next = PROD_CAP;
                end
                else
                begin
                    res_next = shifted[PROD_W-1:0];
                end
                done_next = 1'b1;
            end
            AR_DIV:
            begin
                if (trial >= {1'b0, b_reg[VAL_W-1:0]})
                begin
                    rem_next = VAL_W'(trial - {1'b0, b_reg[VAL_W-1:0]});
                    quo_next = {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[VAL_W-1:0];
                    quo_next = {quo_reg[NW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
            end
            AR_CAP:
            begin
                if (quo_ext > 64'hFFFF_FFFF_FFFF)
                begin
                    res_next = PROD_W'(64'hFFFF_FFFF_FFFF);
                end
                else
                begin
                    res_next = quo_ext[PROD_W-1:0];
                end
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AR_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
        zero_reg <= zero_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.zero_div = zero_reg;
    assign rsp.result   = res_reg;

endmodule

// ===== design/smr_back.sv =====
// smr_back: step sequencer over the shared arithmetic unit, region state, sums and result word
// depends on smr_pkg
module smr_back
    import smr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0] wr_data,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_take,
    output arith_req_t       req,
    input  arith_rsp_t       rsp,
    output logic             empty,
    input  logic             pop,
    output out_word_t        result
);

    localparam logic [STEP_W-1:0] LAST_REGION   = STEP_W'(10);
    localparam logic [STEP_W-1:0] LAST_NEIGHBOR = STEP_W'(16);

    bk_state_t         state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    cmd_t              cur_reg;
    cfg_t              cfg_reg;
    logic [PROD_W-1:0] tmp_reg [TMP_N];

    logic [VAL_W-1:0]        own_s_reg, own_e_reg, own_u_reg, own_rcp_reg;
    logic signed [SUM_W-1:0] sum_s_reg, sum_e_reg, sum_u_reg, sum_p_reg;
    logic signed [OUT_W-1:0] held_doc_reg;
    logic                    fault_reg;
    out_word_t               out_reg;
    logic                    out_valid_reg;

    logic [STEP_W-1:0] last_step;
    logic              is_nbr;
    logic [PROD_W-1:0] dif_s, dif_e, dif_u;
    logic signed [63:0] ab, t_s, t_e, t_u, t_p;
    logic              load_out;

    assign is_nbr    = (cur_reg.item.mode == MODE_NEIGHBOR);
    assign last_step = is_nbr ? LAST_NEIGHBOR : LAST_REGION;
    assign cmd_take  = (state_reg == BK_IDLE) && cmd_valid;
    assign load_out  = (state_reg == BK_EMIT) && (!out_valid_reg || pop);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_BETA:  cfg_reg.beta  <= wr_data;
                REG_MU:    cfg_reg.mu    <= wr_data[16:0];
                REG_ALPHA: cfg_reg.alpha <= wr_data[16:0];
                REG_INV_Z: cfg_reg.inv_z <= wr_data[16:0];
                REG_INV_D: cfg_reg.inv_d <= wr_data[16:0];
                REG_THETA: cfg_reg.theta <= wr_data;
                default:   ;
            endcase
        end
    end

    // exchange differences
    always_comb
    begin
        dif_s = (tmp_reg[2] >= tmp_reg[8])  ? tmp_reg[2] - tmp_reg[8]  : tmp_reg[8] - tmp_reg[2];
        dif_e = (tmp_reg[4] >= tmp_reg[10]) ? tmp_reg[4] - tmp_reg[10] : tmp_reg[10] - tmp_reg[4];
        dif_u = (tmp_reg[6] >= tmp_reg[12]) ? tmp_reg[6] - tmp_reg[12] : tmp_reg[12] - tmp_reg[6];
    end

    // step operands
    always_comb
    begin
        req.start = (state_reg == BK_ISSUE);
        req.op    = OP_MUL;
        req.sh    = SH_FRAC;
        req.a     = '0;
        req.b     = '0;
        if (!is_nbr)
        begin
            case (step_reg)
                5'd0:
                begin
                    req.op = OP_DIV;
                    req.b  = OPW'(cur_reg.item.population);
                end
                5'd1:
                begin
                    req.a  = OPW'(cur_reg.item.susceptible);
                    req.b  = OPW'(tmp_reg[0]);
                    req.sh = SH_WORD;
                end
                5'd2:
                begin
                    req.a = OPW'(tmp_reg[1]);
                    req.b = OPW'(cfg_reg.beta);
                end
                5'd3:
                begin
                    req.a = OPW'(tmp_reg[2]);
                    req.b = OPW'(cur_reg.inf_sum);
                end
                5'd4:
                begin
                    req.a = OPW'(tmp_reg[2]);
                    req.b = OPW'(cfg_reg.mu);
                end
                5'd5:
                begin
                    req.a = OPW'(tmp_reg[4]);
                    req.b = OPW'(cur_reg.item.undocumented);
                end
                5'd6:
                begin
                    req.a = OPW'(cur_reg.item.exposed);
                    req.b = OPW'(cfg_reg.inv_z);
                end
                5'd7:
                begin
                    req.a = OPW'(tmp_reg[6]);
                    req.b = OPW'(cfg_reg.alpha);
                end
                5'd8:
                begin
                    req.a = OPW'(cur_reg.item.documented);
                    req.b = OPW'(cfg_reg.inv_d);
                end
                5'd9:
                begin
                    req.a = OPW'(cur_reg.item.undocumented);
                    req.b = OPW'(cfg_reg.inv_d);
                end
                default:
                begin
                    req.op = OP_DIV;
                    req.b  = OPW'(cur_reg.exch_base);
                end
            endcase
        end
        else
        begin
            case (step_reg)
                5'd0:
                begin
                    req.op = OP_DIV;
                    req.b  = OPW'(cur_reg.exch_base);
                end
                5'd1:
                begin
                    req.a  = OPW'(cur_reg.item.susceptible);
                    req.b  = OPW'(tmp_reg[0]);
                    req.sh = SH_WORD;
                end
                5'd2:
                begin
                    req.a  = OPW'(tmp_reg[1]);
                    req.b  = OPW'(cur_reg.item.flow_in);
                    req.sh = SH_NONE;
                end
                5'd3:
                begin
                    req.a  = OPW'(cur_reg.item.exposed);
                    req.b  = OPW'(tmp_reg[0]);
                    req.sh = SH_WORD;
                end
                5'd4:
                begin
                    req.a  = OPW'(tmp_reg[3]);
                    req.b  = OPW'(cur_reg.item.flow_in);
                    req.sh = SH_NONE;
                end
                5'd5:
                begin
                    req.a  = OPW'(cur_reg.item.undocumented);
                    req.b  = OPW'(tmp_reg[0]);
                    req.sh = SH_WORD;
                end
                5'd6:
                begin
                    req.a  = OPW'(tmp_reg[5]);
                    req.b  = OPW'(cur_reg.item.flow_in);
                    req.sh = SH_NONE;
                end
                5'd7:
                begin
                    req.a  = OPW'(own_s_reg);
                    req.b  = OPW'(own_rcp_reg);
                    req.sh = SH_WORD;
                end
                5'd8:
                begin
                    req.a  = OPW'(tmp_reg[7]);
                    req.b  = OPW'(cur_reg.item.flow_out);
                    req.sh = SH_NONE;
                end
                5'd9:
                begin
                    req.a  = OPW'(own_e_reg);
                    req.b  = OPW'(own_rcp_reg);
                    req.sh = SH_WORD;
                end
                5'd10:
                begin
                    req.a  = OPW'(tmp_reg[9]);
                    req.b  = OPW'(cur_reg.item.flow_out);
                    req.sh = SH_NONE;
                end
                5'd11:
                begin
                    req.a  = OPW'(own_u_reg);
                    req.b  = OPW'(own_rcp_reg);
                    req.sh = SH_WORD;
                end
                5'd12:
                begin
                    req.a  = OPW'(tmp_reg[11]);
                    req.b  = OPW'(cur_reg.item.flow_out);
                    req.sh = SH_NONE;
                end
                5'd13:
                begin
                    req.a = OPW'(dif_s);
                    req.b = OPW'(cfg_reg.theta);
                end
                5'd14:
                begin
                    req.a = OPW'(dif_e);
                    req.b = OPW'(cfg_reg.theta);
                end
                5'd15:
                begin
                    req.a = OPW'(dif_u);
                    req.b = OPW'(cfg_reg.theta);
                end
                default:
                begin
                    req.a  = OPW'(cur_reg.flow_mag);
                    req.b  = OPW'(cfg_reg.theta);
                    req.sh = SH_NONE;
                end
            endcase
        end
    end

    // signed terms for the sum update
    always_comb
    begin
        ab  = to_s64(tmp_reg[3]) + to_s64(tmp_reg[5]);
        t_s = (tmp_reg[2] >= tmp_reg[8])  ? to_s64(tmp_reg[13]) : -to_s64(tmp_reg[13]);
        t_e = (tmp_reg[4] >= tmp_reg[10]) ? to_s64(tmp_reg[14]) : -to_s64(tmp_reg[14]);
        t_u = (tmp_reg[6] >= tmp_reg[12]) ? to_s64(tmp_reg[15]) : -to_s64(tmp_reg[15]);
        t_p = cur_reg.flow_neg ? -to_s64(tmp_reg[16]) : to_s64(tmp_reg[16]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = BK_ISSUE;
                end
            end
            BK_ISSUE: state_next = BK_WAIT;
            BK_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = (step_reg == last_step) ? BK_FINISH : BK_ISSUE;
                end
            end
            BK_FINISH: state_next = cur_reg.item.last_of_region ? BK_EMIT : BK_IDLE;
            BK_EMIT:
            begin
                if (load_out)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // step counter
    always_comb
    begin
        step_next = step_reg;
        unique case (state_reg)
            BK_IDLE: step_next = '0;
            BK_WAIT:
            begin
                if (rsp.done && step_reg != last_step)
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // current word and step results
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cur_reg <= cmd;
        end
        if (state_reg == BK_WAIT && rsp.done)
        begin
            tmp_reg[step_reg] <= rsp.result;
        end
    end

    // region state, sums and fault flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_s_reg    <= '0;
            own_e_reg    <= '0;
            own_u_reg    <= '0;
            own_rcp_reg  <= '0;
            sum_s_reg    <= '0;
            sum_e_reg    <= '0;
            sum_u_reg    <= '0;
            sum_p_reg    <= '0;
            held_doc_reg <= '0;
            fault_reg    <= 1'b0;
        end
        else
        begin
            if (cmd_take && cmd.item.mode == MODE_REGION)
            begin
                fault_reg <= 1'b0;
            end
            else if (state_reg == BK_WAIT && rsp.done && rsp.zero_div)
            begin
                fault_reg <= 1'b1;
            end
            if (state_reg == BK_FINISH)
            begin
                if (!is_nbr)
                begin
                    sum_s_reg    <= SUM_W'(sat_bits(-ab, SUM_W));
                    sum_e_reg    <= SUM_W'(sat_bits(ab - to_s64(tmp_reg[6]), SUM_W));
                    held_doc_reg <= OUT_W'(sat_bits(to_s64(tmp_reg[7]) - to_s64(tmp_reg[8]),
                                                    OUT_W));
                    sum_u_reg    <= SUM_W'(sat_bits(to_s64(tmp_reg[6]) - to_s64(tmp_reg[7])
                                                    - to_s64(tmp_reg[9]), SUM_W));
                    sum_p_reg    <= '0;
                    own_s_reg    <= cur_reg.item.susceptible;
                    own_e_reg    <= cur_reg.item.exposed;
                    own_u_reg    <= cur_reg.item.undocumented;
                    own_rcp_reg  <= tmp_reg[10][VAL_W-1:0];
                end
                else
                begin
                    sum_s_reg <= SUM_W'(sat_bits(64'(sum_s_reg) + t_s, SUM_W));
                    sum_e_reg <= SUM_W'(sat_bits(64'(sum_e_reg) + t_e, SUM_W));
                    sum_u_reg <= SUM_W'(sat_bits(64'(sum_u_reg) + t_u, SUM_W));
                    sum_p_reg <= SUM_W'(sat_bits(64'(sum_p_reg) + t_p, SUM_W));
                end
            end
        end
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.rate_susceptible  <= OUT_W'(sat_bits(64'(sum_s_reg), OUT_W));
            out_reg.rate_exposed      <= OUT_W'(sat_bits(64'(sum_e_reg), OUT_W));
            out_reg.rate_documented   <= held_doc_reg;
            out_reg.rate_undocumented <= OUT_W'(sat_bits(64'(sum_u_reg), OUT_W));
            out_reg.rate_population   <= OUT_W'(sat_bits(64'(sum_p_reg), OUT_W));
            out_reg.divide_fault      <= fault_reg;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

// ===== design/seir_metapopulation_rhs.sv =====
// seir_metapopulation_rhs: top level of the epidemic metapopulation derivative block
// depends on smr_pkg, smr_front, smr_arith, smr_back
//
// channel   signals                       word
// input     push / full                   item (in_word_t)
// result    empty / pop                   result (out_word_t)
// config    wr_en, wr_index, wr_data      one register a write, no read-back
//
// each word runs through a step sequence on one shared arithmetic unit:
// a multiply takes four 32x32 partial products, a normalize and a hand-off;
// a reciprocal yields one quotient bit a cycle. region word: two reciprocals
// and nine multiplies; neighbor word: one reciprocal and sixteen multiplies.
// a two-word queue takes new words while the back end works; a finished result
// waits in its own register and stalls only the back end. reset clears the
// control state, configuration, sums and flags, but not the data registers.
module seir_metapopulation_rhs
    import smr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  in_word_t         item,
    output logic             empty,
    input  logic             pop,
    output out_word_t        result,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0] wr_data
);

    logic       cmd_valid;
    logic       cmd_take;
    cmd_t       cmd;
    arith_req_t req;
    arith_rsp_t rsp;

    // front end: classify and queue
    smr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // shared multiply and reciprocal unit
    smr_arith #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // back end: step sequencer and result register
    smr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .req       (req),
        .rsp       (rsp),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
